### hdl/pmm_pkg.sv
// Shared constants, types and codes of the paged memory manager.
package pmm_pkg;

   localparam int PAGE_OFFSET_BITS = 8;
   localparam int PHYS_PAGES       = 64;
   localparam int MAX_PROCESSES    = 15;

   localparam int PAGE_BITS  = $clog2(PHYS_PAGES);
   localparam int LINK_BITS  = PAGE_BITS + 1;
   localparam int VADDR_BITS = 14;
   localparam int VPAGE_BITS = VADDR_BITS - PAGE_OFFSET_BITS;
   localparam int PID_BITS   = 4;
   localparam int MAP_BITS   = PID_BITS + VPAGE_BITS;
   localparam int RAM_BITS   = PAGE_BITS + PAGE_OFFSET_BITS;
   localparam int BRK_BITS   = VADDR_BITS + 1;
   localparam int SIZE_BITS  = 16;
   localparam int NPG_BITS   = SIZE_BITS + 1 - PAGE_OFFSET_BITS;
   localparam int START_BITS = 7;
   localparam int CLR_BITS   = (RAM_BITS > MAP_BITS) ? RAM_BITS : MAP_BITS;
   localparam int NPROC      = 1 << PID_BITS;

   localparam logic [BRK_BITS-1:0]  VSPACE   = BRK_BITS'(1 << VADDR_BITS);
   localparam logic [LINK_BITS-1:0] LINK_END = LINK_BITS'(PHYS_PAGES);

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOMEM    = 2'd1;
   localparam logic [1:0] ST_UNMAPPED = 2'd2;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_WRITE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_ALLOC_SCAN,
      S_ALLOC_LAST,
      S_FREE_WALK,
      S_RAM_RD
   } state_type;

   typedef struct packed {
      logic [PID_BITS-1:0]   owner;
      logic [LINK_BITS-1:0]  link;
      logic [VPAGE_BITS-1:0] vpage;
   } page_entry_type;

   typedef struct packed {
      logic                 we;
      logic [PAGE_BITS-1:0] waddr;
      page_entry_type       wdata;
      logic [PAGE_BITS-1:0] raddr;
   } page_port_type;

   typedef struct packed {
      logic                 we;
      logic [MAP_BITS-1:0]  waddr;
      logic [LINK_BITS-1:0] wdata;
      logic [MAP_BITS-1:0]  raddr;
   } map_port_type;

   typedef struct packed {
      logic                we;
      logic [RAM_BITS-1:0] waddr;
      logic [7:0]          wdata;
      logic [RAM_BITS-1:0] raddr;
   } ram_port_type;

endpackage

### hdl/paged_memory_manager_core.sv
// Top level of the paged memory manager: stream ports, control and the three memories.
//
// After reset the block runs a clearing pass over its byte RAM, page map and page table, and
// takes no item until it ends; the break-start register may be written at any time while
// idle. Each item gives one result. A write or a failed lookup ends in the lookup state, and a
// read goes on to a byte RAM read state; an allocate that is refused or asks for no bytes is
// answered without a scan. An allocate that succeeds scans the physical pages in order up to
// the last page it takes, and a free walks the chain of pages it releases, both through the
// single read port of the page table, one entry per cycle.
module paged_memory_manager_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // process_id, alloc_size, virtual_address, write_byte, zero pad
   input  logic [1:0]  req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // alloc_address, read_byte, zero pad
   output logic [1:0]  rsp_tuser,  // status
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);

   pmm_pkg::page_port_type                page_port;
   pmm_pkg::page_entry_type               page_rdata;
   pmm_pkg::map_port_type                 map_port;
   logic [pmm_pkg::LINK_BITS-1:0]         map_rdata;
   pmm_pkg::ram_port_type                 ram_port;
   logic [7:0]                            ram_rdata;
   logic [pmm_pkg::BRK_BITS-1:0]          rsp_addr;
   logic [7:0]                            rsp_rb;
   logic [$bits(pmm_pkg::page_entry_type)-1:0] page_rbits;

   pmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (pmm_pkg::cmd_type'(req_tuser)),
      .req_pid    (req_tdata[3:0]),
      .req_size   (req_tdata[19:4]),
      .req_va     (req_tdata[33:20]),
      .req_wb     (req_tdata[41:34]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_addr   (rsp_addr),
      .rsp_rb     (rsp_rb),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .page_port  (page_port),
      .page_rdata (page_rdata),
      .map_port   (map_port),
      .map_rdata  (map_rdata),
      .ram_port   (ram_port),
      .ram_rdata  (ram_rdata)
   );

   pmm_ram #(
      .ADDR_BITS (pmm_pkg::PAGE_BITS),
      .DATA_BITS ($bits(pmm_pkg::page_entry_type))
   ) u_page_table (
      .clock (clock),
      .we    (page_port.we),
      .waddr (page_port.waddr),
      .wdata (page_port.wdata),
      .raddr (page_port.raddr),
      .rdata (page_rbits)
   );

   assign page_rdata = pmm_pkg::page_entry_type'(page_rbits);

   pmm_ram #(
      .ADDR_BITS (pmm_pkg::MAP_BITS),
      .DATA_BITS (pmm_pkg::LINK_BITS)
   ) u_page_map (
      .clock (clock),
      .we    (map_port.we),
      .waddr (map_port.waddr),
      .wdata (map_port.wdata),
      .raddr (map_port.raddr),
      .rdata (map_rdata)
   );

   pmm_ram #(
      .ADDR_BITS (pmm_pkg::RAM_BITS),
      .DATA_BITS (8)
   ) u_byte_ram (
      .clock (clock),
      .we    (ram_port.we),
      .waddr (ram_port.waddr),
      .wdata (ram_port.wdata),
      .raddr (ram_port.raddr),
      .rdata (ram_rdata)
   );

   assign rsp_tdata = {1'b0, rsp_rb, rsp_addr};

endmodule

### hdl/pmm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pmm_ram #(
   parameter int ADDR_BITS = 6,
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [DATA_BITS-1:0] wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/pmm_ctrl.sv
// Command sequencer: clearing pass, allocate scan, free walk, byte access, break pointers.
module pmm_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pmm_pkg::cmd_type                     req_cmd,
   input  logic [pmm_pkg::PID_BITS-1:0]         req_pid,
   input  logic [pmm_pkg::SIZE_BITS-1:0]        req_size,
   input  logic [pmm_pkg::VADDR_BITS-1:0]       req_va,
   input  logic [7:0]                           req_wb,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [pmm_pkg::BRK_BITS-1:0]         rsp_addr,
   output logic [7:0]                           rsp_rb,
   input  logic                                 csr_we,
   input  logic [pmm_pkg::START_BITS-1:0]       csr_wdata,
   output pmm_pkg::page_port_type               page_port,
   input  pmm_pkg::page_entry_type              page_rdata,
   output pmm_pkg::map_port_type                map_port,
   input  logic [pmm_pkg::LINK_BITS-1:0]        map_rdata,
   output pmm_pkg::ram_port_type                ram_port,
   input  logic [7:0]                           ram_rdata
);

   pmm_pkg::state_type                  state_ff, state_in;
   pmm_pkg::cmd_type                    cmd_ff, cmd_in;
   logic [pmm_pkg::PID_BITS-1:0]        pid_ff, pid_in;
   logic [pmm_pkg::VADDR_BITS-1:0]      va_ff, va_in;
   logic [7:0]                          wb_ff, wb_in;
   logic [pmm_pkg::LINK_BITS-1:0]       n_ff, n_in;
   logic [pmm_pkg::LINK_BITS-1:0]       k_ff, k_in;
   logic [pmm_pkg::VPAGE_BITS-1:0]      vbase_ff, vbase_in;
   logic [pmm_pkg::LINK_BITS-1:0]       scan_ff, scan_in;
   logic                                rdv_ff, rdv_in;
   logic [pmm_pkg::PAGE_BITS-1:0]       rdidx_ff, rdidx_in;
   logic [pmm_pkg::PAGE_BITS-1:0]       pend_ff, pend_in;
   logic [pmm_pkg::VPAGE_BITS-1:0]      pendvp_ff, pendvp_in;
   logic                                haspend_ff, haspend_in;
   logic [pmm_pkg::PAGE_BITS-1:0]       walk_ff, walk_in;
   logic                                first_ff, first_in;
   logic [pmm_pkg::VPAGE_BITS-1:0]      prevvp_ff, prevvp_in;
   logic [pmm_pkg::LINK_BITS-1:0]       freecnt_ff, freecnt_in;
   logic [pmm_pkg::CLR_BITS-1:0]        clr_ff, clr_in;
   logic [pmm_pkg::BRK_BITS-1:0]        addr_ff, addr_in;
   logic [pmm_pkg::BRK_BITS-1:0]        brk_ff [pmm_pkg::NPROC];
   logic [pmm_pkg::BRK_BITS-1:0]        brk_in [pmm_pkg::NPROC];
   logic                                rspv_ff, rspv_in;
   logic [1:0]                          rsps_ff, rsps_in;
   logic [pmm_pkg::BRK_BITS-1:0]        rspa_ff, rspa_in;
   logic [7:0]                          rspb_ff, rspb_in;

   logic                                accept;
   logic                                done;
   logic [1:0]                          d_status;
   logic [pmm_pkg::BRK_BITS-1:0]        d_addr;
   logic [7:0]                          d_rb;
   logic [pmm_pkg::SIZE_BITS:0]         size_up;
   logic [pmm_pkg::NPG_BITS-1:0]        npages;
   logic [pmm_pkg::BRK_BITS-1:0]        bp;
   logic [pmm_pkg::BRK_BITS+2:0]        brk_sum;
   logic                                pid_ok;
   logic [pmm_pkg::PAGE_BITS-1:0]       epage;
   logic [pmm_pkg::BRK_BITS-1:0]        reload;

   assign req_ready = (state_ff == pmm_pkg::S_IDLE) && (!rspv_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign size_up   = {1'b0, req_size} + (pmm_pkg::SIZE_BITS+1)'((1 << pmm_pkg::PAGE_OFFSET_BITS) - 1);
   assign npages    = size_up[pmm_pkg::SIZE_BITS:pmm_pkg::PAGE_OFFSET_BITS];
   assign bp        = brk_ff[req_pid];
   assign brk_sum   = {3'b0, bp} + (pmm_pkg::BRK_BITS+3)'({npages, {pmm_pkg::PAGE_OFFSET_BITS{1'b0}}});
   assign pid_ok    = (req_pid != '0) && (32'(req_pid) <= pmm_pkg::MAX_PROCESSES);
   assign epage     = pmm_pkg::PAGE_BITS'(map_rdata - pmm_pkg::LINK_BITS'(1));
   assign reload    = (32'(csr_wdata) > (1 << pmm_pkg::VPAGE_BITS)) ? pmm_pkg::VSPACE :
                      pmm_pkg::BRK_BITS'({csr_wdata, {pmm_pkg::PAGE_OFFSET_BITS{1'b0}}});

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      pid_in     = pid_ff;
      va_in      = va_ff;
      wb_in      = wb_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      vbase_in   = vbase_ff;
      scan_in    = scan_ff;
      rdv_in     = 1'b0;
      rdidx_in   = rdidx_ff;
      pend_in    = pend_ff;
      pendvp_in  = pendvp_ff;
      haspend_in = haspend_ff;
      walk_in    = walk_ff;
      first_in   = first_ff;
      prevvp_in  = prevvp_ff;
      freecnt_in = freecnt_ff;
      clr_in     = clr_ff;
      addr_in    = addr_ff;
      brk_in     = brk_ff;
      done       = 1'b0;
      d_status   = pmm_pkg::ST_OK;
      d_addr     = '0;
      d_rb       = '0;
      page_port  = '0;
      map_port   = '0;
      ram_port   = '0;

      case (state_ff)
         pmm_pkg::S_CLEAR: begin
            page_port.we    = 1'b1;
            page_port.waddr = clr_ff[pmm_pkg::PAGE_BITS-1:0];
            map_port.we     = 1'b1;
            map_port.waddr  = clr_ff[pmm_pkg::MAP_BITS-1:0];
            ram_port.we     = 1'b1;
            ram_port.waddr  = clr_ff[pmm_pkg::RAM_BITS-1:0];
            clr_in          = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = pmm_pkg::S_IDLE;
            end
         end
         pmm_pkg::S_IDLE: begin
            map_port.raddr = {req_pid, req_va[pmm_pkg::VADDR_BITS-1:pmm_pkg::PAGE_OFFSET_BITS]};
            if (accept) begin
               cmd_in = req_cmd;
               pid_in = req_pid;
               va_in  = req_va;
               wb_in  = req_wb;
               if (req_cmd == pmm_pkg::CMD_ALLOC) begin
                  if (!pid_ok) begin
                     done     = 1'b1;
                     d_status = pmm_pkg::ST_NOMEM;
                  end else if (npages == '0) begin
                     done   = 1'b1;
                     d_addr = bp;
                  end else if ((pmm_pkg::NPG_BITS'(freecnt_ff) < npages) ||
                               (brk_sum > (pmm_pkg::BRK_BITS+3)'(pmm_pkg::VSPACE))) begin
                     done     = 1'b1;
                     d_status = pmm_pkg::ST_NOMEM;
                  end else begin
                     n_in            = pmm_pkg::LINK_BITS'(npages);
                     k_in            = '0;
                     vbase_in        = bp[pmm_pkg::VADDR_BITS-1:pmm_pkg::PAGE_OFFSET_BITS];
                     scan_in         = '0;
                     haspend_in      = 1'b0;
                     addr_in         = bp;
                     brk_in[req_pid] = pmm_pkg::BRK_BITS'(brk_sum);
                     freecnt_in      = freecnt_ff - pmm_pkg::LINK_BITS'(npages);
                     state_in        = pmm_pkg::S_ALLOC_SCAN;
                  end
               end else if (!pid_ok) begin
                  done     = 1'b1;
                  d_status = pmm_pkg::ST_UNMAPPED;
               end else begin
                  state_in = pmm_pkg::S_LOOK;
               end
            end
         end
         pmm_pkg::S_LOOK: begin
            page_port.raddr = epage;
            ram_port.raddr  = {epage, va_ff[pmm_pkg::PAGE_OFFSET_BITS-1:0]};
            if (map_rdata == '0) begin
               done     = 1'b1;
               d_status = pmm_pkg::ST_UNMAPPED;
               state_in = pmm_pkg::S_IDLE;
            end else begin
               case (cmd_ff)
                  pmm_pkg::CMD_FREE: begin
                     walk_in  = epage;
                     first_in = 1'b1;
                     state_in = pmm_pkg::S_FREE_WALK;
                  end
                  pmm_pkg::CMD_READ: begin
                     state_in = pmm_pkg::S_RAM_RD;
                  end
                  pmm_pkg::CMD_WRITE: begin
                     ram_port.we    = 1'b1;
                     ram_port.waddr = {epage, va_ff[pmm_pkg::PAGE_OFFSET_BITS-1:0]};
                     ram_port.wdata = wb_ff;
                     done           = 1'b1;
                     state_in       = pmm_pkg::S_IDLE;
                  end
                  default: begin
                     state_in = pmm_pkg::S_IDLE;
                  end
               endcase
            end
         end
         pmm_pkg::S_RAM_RD: begin
            done     = 1'b1;
            d_rb     = ram_rdata;
            state_in = pmm_pkg::S_IDLE;
         end
         pmm_pkg::S_ALLOC_SCAN: begin
            page_port.raddr = scan_ff[pmm_pkg::PAGE_BITS-1:0];
            rdv_in          = (32'(scan_ff) < pmm_pkg::PHYS_PAGES);
            rdidx_in        = scan_ff[pmm_pkg::PAGE_BITS-1:0];
            if (rdv_in) begin
               scan_in = scan_ff + 1'b1;
            end
            if (rdv_ff && (page_rdata.owner == '0)) begin
               if (haspend_ff) begin
                  page_port.we          = 1'b1;
                  page_port.waddr       = pend_ff;
                  page_port.wdata.owner = pid_ff;
                  page_port.wdata.link  = {1'b0, rdidx_ff};
                  page_port.wdata.vpage = pendvp_ff;
               end
               map_port.we    = 1'b1;
               map_port.waddr = {pid_ff, vbase_ff + pmm_pkg::VPAGE_BITS'(k_ff)};
               map_port.wdata = {1'b0, rdidx_ff} + pmm_pkg::LINK_BITS'(1);
               pend_in        = rdidx_ff;
               pendvp_in      = vbase_ff + pmm_pkg::VPAGE_BITS'(k_ff);
               haspend_in     = 1'b1;
               k_in           = k_ff + 1'b1;
               if (k_in == n_ff) begin
                  state_in = pmm_pkg::S_ALLOC_LAST;
               end
            end
         end
         pmm_pkg::S_ALLOC_LAST: begin
            page_port.we          = 1'b1;
            page_port.waddr       = pend_ff;
            page_port.wdata.owner = pid_ff;
            page_port.wdata.link  = pmm_pkg::LINK_END;
            page_port.wdata.vpage = pendvp_ff;
            done                  = 1'b1;
            d_addr                = addr_ff;
            state_in              = pmm_pkg::S_IDLE;
         end
         pmm_pkg::S_FREE_WALK: begin
            page_port.raddr = page_rdata.link[pmm_pkg::PAGE_BITS-1:0];
            if (first_ff || ((page_rdata.owner == pid_ff) &&
                 ({1'b0, page_rdata.vpage} == {1'b0, prevvp_ff} + 1'b1))) begin
               page_port.we          = 1'b1;
               page_port.waddr       = walk_ff;
               page_port.wdata.owner = '0;
               page_port.wdata.link  = page_rdata.link;
               page_port.wdata.vpage = page_rdata.vpage;
               map_port.we           = 1'b1;
               map_port.waddr        = {pid_ff, page_rdata.vpage};
               freecnt_in            = freecnt_ff + 1'b1;
               prevvp_in             = page_rdata.vpage;
               first_in              = 1'b0;
               walk_in               = page_rdata.link[pmm_pkg::PAGE_BITS-1:0];
               if (page_rdata.link >= pmm_pkg::LINK_END) begin
                  done     = 1'b1;
                  state_in = pmm_pkg::S_IDLE;
               end
            end else begin
               done     = 1'b1;
               state_in = pmm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pmm_pkg::S_IDLE;
         end
      endcase

      rspv_in = (rspv_ff && !rsp_ready) || done;
      rsps_in = done ? d_status : rsps_ff;
      rspa_in = done ? d_addr : rspa_ff;
      rspb_in = done ? d_rb : rspb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pmm_pkg::S_CLEAR;
         clr_ff     <= '0;
         freecnt_ff <= pmm_pkg::LINK_BITS'(pmm_pkg::PHYS_PAGES);
         rspv_ff    <= 1'b0;
         rdv_ff     <= 1'b0;
         haspend_ff <= 1'b0;
         first_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         freecnt_ff <= freecnt_in;
         rspv_ff    <= rspv_in;
         rdv_ff     <= rdv_in;
         haspend_ff <= haspend_in;
         first_ff   <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pmm_pkg::NPROC; i++) begin
            brk_ff[i] <= pmm_pkg::BRK_BITS'(1 << pmm_pkg::PAGE_OFFSET_BITS);
         end
      end else if (csr_we) begin
         for (int i = 0; i < pmm_pkg::NPROC; i++) begin
            brk_ff[i] <= reload;
         end
      end else begin
         brk_ff <= brk_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pid_ff    <= pid_in;
      va_ff     <= va_in;
      wb_ff     <= wb_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      vbase_ff  <= vbase_in;
      scan_ff   <= scan_in;
      rdidx_ff  <= rdidx_in;
      pend_ff   <= pend_in;
      pendvp_ff <= pendvp_in;
      walk_ff   <= walk_in;
      prevvp_ff <= prevvp_in;
      addr_ff   <= addr_in;
      rsps_ff   <= rsps_in;
      rspa_ff   <= rspa_in;
      rspb_ff   <= rspb_in;
   end

   assign rsp_valid  = rspv_ff;
   assign rsp_status = rsps_ff;
   assign rsp_addr   = rspa_ff;
   assign rsp_rb     = rspb_ff;

endmodule

### dv/testbench.sv
// Self-checking testbench for the paged memory manager core: directed and random items.
`timescale 1ns / 100ps

module testbench;

   localparam int PG_BYTES = 1 << pmm_pkg::PAGE_OFFSET_BITS;
   localparam int NVPAGES  = (1 << pmm_pkg::VADDR_BITS) / PG_BYTES;
   localparam int WD_LIMIT = 60000;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] address;
      logic [7:0]  data;
   } answer_type;

   typedef struct {
      int pid;
      int base;
      int span;
   } region_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;

   int         fails = 0;
   int         quiet = 0;
   bit         calm = 1'b0;
   answer_type answers[$];
   region_type regions[$];

   int owner_tab[pmm_pkg::PHYS_PAGES];
   int link_tab[pmm_pkg::PHYS_PAGES];
   int vpage_tab[pmm_pkg::PHYS_PAGES];
   int page_map[pmm_pkg::NPROC*NVPAGES];
   int brk_tab[pmm_pkg::NPROC];
   logic [7:0] mem_bytes[pmm_pkg::PHYS_PAGES*PG_BYTES];

   always #2 clock = ~clock;

   paged_memory_manager_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   function automatic void reload_breaks(int start);
      int b;
      b = start * PG_BYTES;
      if (b > (1 << pmm_pkg::VADDR_BITS)) b = 1 << pmm_pkg::VADDR_BITS;
      for (int i = 0; i < pmm_pkg::NPROC; i++) brk_tab[i] = b;
   endfunction

   function automatic answer_type manage(pmm_pkg::cmd_type cmd, int pid, int size, int va,
                                         int wb);
      answer_type r;
      int n, avail, bp, vp, k, prev, e, pa, p, nx, v;
      bit ok, mapped;
      r = '0;
      ok = pid != 0 && pid <= pmm_pkg::MAX_PROCESSES;
      mapped = 0;
      if (ok) begin
         e = page_map[pid*NVPAGES + (va >> pmm_pkg::PAGE_OFFSET_BITS)];
         if (e != 0 && e <= pmm_pkg::PHYS_PAGES) begin
            mapped = 1;
            pa = ((e - 1) << pmm_pkg::PAGE_OFFSET_BITS) | (va & (PG_BYTES - 1));
         end
      end
      if (cmd == pmm_pkg::CMD_ALLOC) begin
         n = (size + PG_BYTES - 1) >> pmm_pkg::PAGE_OFFSET_BITS;
         if (!ok) r.status = pmm_pkg::ST_NOMEM;
         else if (n == 0) r.address = brk_tab[pid];
         else begin
            avail = 0;
            bp = brk_tab[pid];
            for (int i = 0; i < pmm_pkg::PHYS_PAGES; i++) if (owner_tab[i] == 0) avail++;
            if (avail < n || bp + (n << pmm_pkg::PAGE_OFFSET_BITS) > (1 << pmm_pkg::VADDR_BITS))
               r.status = pmm_pkg::ST_NOMEM;
            else begin
               vp = bp >> pmm_pkg::PAGE_OFFSET_BITS;
               k = 0;
               prev = 0;
               r.address = bp;
               brk_tab[pid] = bp + (n << pmm_pkg::PAGE_OFFSET_BITS);
               for (int i = 0; i < pmm_pkg::PHYS_PAGES && k < n; i++) begin
                  if (owner_tab[i] == 0) begin
                     owner_tab[i] = pid;
                     vpage_tab[i] = vp + k;
                     link_tab[i] = pmm_pkg::PHYS_PAGES;
                     if (k != 0) link_tab[prev] = i;
                     page_map[pid*NVPAGES + vp + k] = i + 1;
                     prev = i;
                     k++;
                  end
               end
            end
         end
      end else if (!mapped) r.status = pmm_pkg::ST_UNMAPPED;
      else if (cmd == pmm_pkg::CMD_FREE) begin
         p = pa >> pmm_pkg::PAGE_OFFSET_BITS;
         for (int s = 0; s < pmm_pkg::PHYS_PAGES; s++) begin
            nx = link_tab[p];
            v = vpage_tab[p];
            owner_tab[p] = 0;
            if (v < NVPAGES) page_map[pid*NVPAGES + v] = 0;
            if (nx >= pmm_pkg::PHYS_PAGES) break;
            if (owner_tab[nx] != pid || vpage_tab[nx] != v + 1) break;
            p = nx;
         end
      end else if (cmd == pmm_pkg::CMD_READ) r.data = mem_bytes[pa];
      else mem_bytes[pa] = wb[7:0];
      return r;
   endfunction

   task automatic send_item(pmm_pkg::cmd_type cmd, int pid, int size, int va, int wb);
      answer_type r;
      if (!calm && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tuser <= cmd;
      req_tdata <= {6'd0, wb[7:0], va[13:0], size[15:0], pid[3:0]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      r = manage(cmd, pid, size, va, wb);
      answers.push_back(r);
      if (cmd == pmm_pkg::CMD_ALLOC && r.status == pmm_pkg::ST_OK && size != 0) begin
         regions.push_back('{pid, int'(r.address), size});
         if (regions.size() > 48) void'(regions.pop_front());
      end
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (answers.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_break_start(int start);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= start[6:0];
      @(posedge clock);
      csr_we <= 1'b0;
      reload_breaks(start);
   endtask

   task automatic test_edges;
      send_item(pmm_pkg::CMD_ALLOC, 1, 0, 0, 0);
      send_item(pmm_pkg::CMD_ALLOC, 1, 1, 0, 0);
      send_item(pmm_pkg::CMD_ALLOC, 2, 256, 0, 0);
      send_item(pmm_pkg::CMD_ALLOC, 2, 257, 0, 0);
      send_item(pmm_pkg::CMD_ALLOC, 15, 65535, 0, 0);
      send_item(pmm_pkg::CMD_WRITE, 1, 0, 256, 255);
      send_item(pmm_pkg::CMD_WRITE, 1, 0, 511, 8'h5a);
      send_item(pmm_pkg::CMD_READ, 1, 0, 256, 0);
      send_item(pmm_pkg::CMD_READ, 1, 0, 511, 0);
      send_item(pmm_pkg::CMD_READ, 2, 0, 16383, 0);
      send_item(pmm_pkg::CMD_WRITE, 15, 0, 16383, 0);
      send_item(pmm_pkg::CMD_FREE, 2, 0, 1024 + 77, 0);
      send_item(pmm_pkg::CMD_READ, 2, 0, 1024, 0);
      send_item(pmm_pkg::CMD_FREE, 3, 0, 256, 0);
      send_item(pmm_pkg::CMD_ALLOC, 15, 16384 - 256, 0, 0);
      send_item(pmm_pkg::CMD_ALLOC, 15, 256, 0, 0);
   endtask

   task automatic test_bad_ids;
      send_item(pmm_pkg::CMD_ALLOC, 0, 300, 0, 0);
      send_item(pmm_pkg::CMD_FREE, 0, 0, 256, 0);
      send_item(pmm_pkg::CMD_READ, 0, 0, 256, 0);
      send_item(pmm_pkg::CMD_WRITE, 0, 0, 256, 170);
      send_item(pmm_pkg::CMD_READ, 1, 0, 256, 0);
   endtask

   task automatic test_random(int count);
      int pick, idx, va;
      region_type g;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (regions.size() == 0 && pick >= 10) pick = 0;
         if (pick < 35)
            send_item(pmm_pkg::CMD_ALLOC, $urandom_range(1, 15),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 1100), 0, 0);
         else if (pick < 90) begin
            idx = $urandom_range(0, regions.size() - 1);
            g = regions[idx];
            va = (g.base + $urandom_range(0, g.span - 1)) & 16'h3fff;
            if (pick < 50) begin
               send_item(pmm_pkg::CMD_FREE, g.pid, 0, va, 0);
               regions.delete(idx);
            end else if (pick < 70)
               send_item(pmm_pkg::CMD_WRITE, g.pid, 0, va, $urandom_range(0, 255));
            else send_item(pmm_pkg::CMD_READ, g.pid, 0, va, 0);
         end else
            send_item(pmm_pkg::cmd_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                      $urandom_range(0, 65535), $urandom_range(0, 16383),
                      $urandom_range(0, 255));
      end
   endtask

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(0, 99) >= 16);
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answers.size() == 0) begin
            $display("%0t: unexpected item status=%0d data=%h", $time, rsp_tuser, rsp_tdata);
            fails++;
         end else begin
            want = answers.pop_front();
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
               fails++;
            end
            if (rsp_tdata[14:0] !== want.address) begin
               $display("%0t: address expected %h actual %h", $time, want.address,
                        rsp_tdata[14:0]);
               fails++;
            end
            if (rsp_tdata[22:15] !== want.data) begin
               $display("%0t: byte expected %h actual %h", $time, want.data, rsp_tdata[22:15]);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WD_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      foreach (owner_tab[i]) begin
         owner_tab[i] = 0;
         link_tab[i] = 0;
         vpage_tab[i] = 0;
      end
      foreach (page_map[i]) page_map[i] = 0;
      foreach (mem_bytes[i]) mem_bytes[i] = 8'd0;
      reload_breaks(1);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_edges();
      test_bad_ids();
      test_random(500);
      set_break_start(0);
      test_edges();
      test_random(300);
      calm = 1'b1;
      set_break_start(63);
      test_random(200);
      calm = 1'b0;
      set_break_start(64);
      test_random(100);
      set_break_start(127);
      test_random(50);
      set_break_start(1);
      test_random(450);
      drain();
      repeat (100) @(posedge clock);
      if (fails == 0 && answers.size() == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule

### sim.f
hdl/pmm_pkg.sv
hdl/pmm_ram.sv
hdl/pmm_ctrl.sv
hdl/paged_memory_manager_core.sv
dv/testbench.sv
